// ===== design/sorted_key_table_assert.svh =====
// Assertion macros for the sorted key table.
// Depends on a clock named clock and a synchronous reset named reset in the including module.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SKT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/skt_pkg.sv =====
// Shared types and codes for the sorted key table.
// No dependencies; imported by skt_key_cmp and sorted_key_table.
`default_nettype none

package skt_pkg;

   localparam int DEFAULT_DEPTH = 256;
   localparam int KTYPE_W       = 32;
   localparam int KID_W         = 31;
   localparam int OUT_W         = 9;

   // Request codes
   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [KTYPE_W-1:0] ktype;
      logic [KID_W-1:0]   kid;
   } key_entry_type;

   // Outcome of comparing the probe key against one stored entry
   typedef struct packed {
      logic lt;
      logic eq;
      logic gt;
   } key_order_type;

endpackage

`default_nettype wire

// ===== design/sorted_key_table.sv =====
// Sorted key table: sequencer, entry memory and search/shift control.
// Depends on skt_pkg, skt_key_cmp and sorted_key_table_assert.svh.
//
// Usage
//   Request channel (req_valid / req_stall): one transfer carries an operation
//   code (lookup, insert, remove) and a compound key (type, then id). Code 3
//   behaves as a lookup. Response channel (rsp_valid / rsp_stall): one transfer
//   per request with the status, the match index or insertion point, and the
//   entry count after the request.
//   The search runs on one shared comparator over a memory with one read and
//   one write port; each probe is a read, then a compare. A miss closes on the
//   empty window in a read step, a hit on the compare, and the response is then
//   loaded, with at most ceil(log2(count + 1)) probes. An insert then moves each
//   entry from the insertion point up by one with a read and a write, and ends
//   with the write of the new key; a remove moves each entry above the match
//   down with a read and a write. The memory port sets the shift cost.
//   One request is in work at a time: req_stall is high from acceptance until
//   the result is loaded, and the next transfer can land in the cycle after. A new
//   request is accepted while that result waits on a stalled receiver; its own
//   result holds in the sequencer until the response register frees up.
//   Reset clears the entry count and control state; the memory needs no
//   clearing because only data read from entries below the count is ever used.
`default_nettype none
`include "sorted_key_table_assert.svh"

module sorted_key_table #(
   parameter int TABLE_DEPTH = skt_pkg::DEFAULT_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire  [1:0]               req_type,
   input  wire  [skt_pkg::KTYPE_W-1:0] req_key_type,
   input  wire  [skt_pkg::KID_W-1:0]   req_key_id,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [skt_pkg::OUT_W-1:0] rsp_position,
   output logic [skt_pkg::OUT_W-1:0] rsp_entry_count
);
   import skt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_CMP    = 4'd2;
   localparam logic [3:0] S_INS_RD = 4'd3;
   localparam logic [3:0] S_INS_WR = 4'd4;
   localparam logic [3:0] S_REM_RD = 4'd5;
   localparam logic [3:0] S_REM_WR = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;

   // Control state
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Work registers (no reset needed)
   logic [1:0]    op_ff, op_in;
   key_entry_type key_ff, key_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [1:0]    status_ff, status_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   // Entry memory
   key_entry_type mem [TABLE_DEPTH];
   key_entry_type rdata_ff;
   logic [CW-1:0] rd_addr;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   key_entry_type wr_data;

   logic [CW-1:0] mid_calc;
   key_order_type order;
   logic          search_end;
   logic          search_hit;
   logic [CW-1:0] search_pos;
   logic          rsp_free;

   skt_key_cmp u_cmp (
      .probe (key_ff),
      .entry (rdata_ff),
      .order (order)
   );

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Memory: one read and one write port, read data registered
   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr[AW-1:0]];
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
   end

   // Read address: probe during search, neighbor entry during shifts
   always_comb begin
      case (state_ff)
         S_INS_RD: rd_addr = idx_ff - CW'(1);
         S_REM_RD: rd_addr = idx_ff + CW'(1);
         default:  rd_addr = mid_calc;
      endcase
   end

   // Write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rdata_ff;
      case (state_ff)
         S_INS_RD: begin
            // Gap is open: drop the new key in
            if (idx_ff <= pos_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = key_ff;
            end
         end
         S_INS_WR: wr_en = 1'b1;
         S_REM_WR: wr_en = 1'b1;
         default:  wr_en = 1'b0;
      endcase
   end

   // Search end detection: empty window on a read step, or a match on compare
   always_comb begin
      search_end = 1'b0;
      search_hit = 1'b0;
      search_pos = lo_ff;
      if (state_ff == S_READ && lo_ff >= hi_ff) begin
         search_end = 1'b1;
      end else if (state_ff == S_CMP && order.eq) begin
         search_end = 1'b1;
         search_hit = 1'b1;
         search_pos = mid_ff;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;

      // Retire the response on its transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (search_end) begin
         pos_in = search_pos;
         case (op_ff)
            REQ_INSERT: begin
               if (search_hit) begin
                  status_in = ST_DUPLICATE;
                  state_in  = S_DONE;
               end else if (count_ff == CW'(TABLE_DEPTH)) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_OK;
                  idx_in    = count_ff;
                  state_in  = S_INS_RD;
               end
            end
            REQ_REMOVE: begin
               if (search_hit) begin
                  status_in = ST_OK;
                  idx_in    = search_pos;
                  state_in  = S_REM_RD;
               end else begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end
            end
            default: begin
               status_in = search_hit ? ST_OK : ST_NOT_FOUND;
               state_in  = S_DONE;
            end
         endcase
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_in     = req_type;
                  key_in    = '{ktype: req_key_type, kid: req_key_id};
                  lo_in     = '0;
                  hi_in     = count_ff;
                  state_in  = S_READ;
               end
            end
            S_READ: begin
               // Probe issued to memory; hold its index for the compare
               mid_in   = mid_calc;
               state_in = S_CMP;
            end
            S_CMP: begin
               // Narrow the window around the probe
               if (order.lt) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CW'(1);
               end
               state_in = S_READ;
            end
            S_INS_RD: begin
               if (idx_ff > pos_ff) begin
                  state_in = S_INS_WR;
               end else begin
                  count_in = count_ff + CW'(1);
                  state_in = S_DONE;
               end
            end
            S_INS_WR: begin
               idx_in   = idx_ff - CW'(1);
               state_in = S_INS_RD;
            end
            S_REM_RD: begin
               if ((idx_ff + CW'(1)) < count_ff) begin
                  state_in = S_REM_WR;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            end
            S_REM_WR: begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_REM_RD;
            end
            S_DONE: begin
               // Load the response register once it is free
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = status_ff;
                  rsp_pos_in    = pos_ff;
                  rsp_count_in  = count_ff;
                  state_in      = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = OUT_W'(rsp_pos_ff);
   assign rsp_entry_count = OUT_W'(rsp_count_ff);

   // Checks
   `SKT_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CW'(TABLE_DEPTH), "entry count over depth")
   `SKT_ASSERT_NOW(a_probe_window, state_ff == S_CMP, (lo_ff <= mid_ff) && (mid_ff < hi_ff), "probe outside search window")
   `SKT_ASSERT_NOW(a_write_range, wr_en, wr_addr < CW'(TABLE_DEPTH), "write beyond table")
   `SKT_ASSERT_NEXT(a_insert_count, (state_ff == S_INS_RD) && (idx_ff <= pos_ff), count_ff == $past(count_ff) + CW'(1), "insert did not grow count")

endmodule

`default_nettype wire

// ===== design/skt_key_cmp.sv =====
// Compound key comparator shared by every search probe of the sorted key table.
// Depends on skt_pkg.
`default_nettype none

module skt_key_cmp (
   input  wire skt_pkg::key_entry_type probe,
   input  wire skt_pkg::key_entry_type entry,
   output skt_pkg::key_order_type order
);
   import skt_pkg::*;

   logic type_lt;
   logic type_eq;
   logic id_lt;
   logic id_eq;

   always_comb begin
      type_lt  = probe.ktype < entry.ktype;
      type_eq  = probe.ktype == entry.ktype;
      id_lt    = probe.kid < entry.kid;
      id_eq    = probe.kid == entry.kid;
      order.lt = type_lt || (type_eq && id_lt);
      order.eq = type_eq && id_eq;
      order.gt = !order.lt && !order.eq;
   end

endmodule

`default_nettype wire
